/* hw/rtl/ple_pkg.sv */
// package with request and response types, codes and defaults for the positional list engine
`timescale 1ns / 1ps

package ple_pkg;

   localparam int PLE_CAPACITY = 16;

   localparam logic [1:0] OP_READ   = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [4:0]         position;
      logic signed [31:0] item_value;
   } ple_req_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic [4:0]         entry_count;
      logic [1:0]         status;
   } ple_rsp_type;

   typedef struct packed {
      logic               insert_en;
      logic               remove_en;
      logic [4:0]         pos;
      logic signed [31:0] item;
   } ple_cell_ctrl_type;

endpackage

/* hw/rtl/ple_cell.sv */
// one list cell: holds one entry and shifts with its neighbors on insert and remove
`timescale 1ns / 1ps

module ple_cell #(
   parameter int IDX = 0
) (
   input  logic                       clock,
   input  ple_pkg::ple_cell_ctrl_type ctrl,
   input  logic signed [31:0]         lower_data,
   input  logic signed [31:0]         upper_data,
   output logic signed [31:0]         data,
   output logic signed [31:0]         read_data
);
   import ple_pkg::*;

   logic signed [31:0] data_ff;
   logic signed [31:0] data_in;
   logic               at_pos;
   logic               above_pos;

   assign at_pos    = (IDX == int'(ctrl.pos));
   assign above_pos = (IDX > int'(ctrl.pos));

   always_comb begin
      data_in = data_ff;
      if (ctrl.insert_en) begin
         if (at_pos) begin
            data_in = ctrl.item;
         end else if (above_pos) begin
            data_in = lower_data;
         end
      end else if (ctrl.remove_en) begin
         if (at_pos || above_pos) begin
            data_in = upper_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data      = data_ff;
   assign read_data = at_pos ? data_ff : 32'sd0;

endmodule

/* hw/rtl/positional_list_engine.sv */
// top level of the positional list engine: count, decode, cell row and response register
//
// usage
//   request channel req_valid / req_stall / req_data carries one operation:
//   read, insert or remove at a zero-based position. response channel
//   rsp_valid / rsp_stall / rsp_data returns one response per request with
//   the item read or removed, the count after the request and a status.
//   rsp_valid rises in the cycle after acceptance; one request can be
//   accepted every cycle unless a response waits under rsp_stall, as the
//   cells from the position up load in parallel from a neighbor or the item.
//   a read or remove at a position not below the count returns a range
//   status; an insert into a full list returns a full status; the list is
//   unchanged in both cases. an insert past the end lands at the end.
//   reset empties the list and drops any pending response; cell contents
//   are not cleared and are never read before written.
//   while a response waits under rsp_stall, req_stall is high and no new
//   request is taken; the response and list stay unchanged.
`timescale 1ns / 1ps

module positional_list_engine #(
   parameter int CAPACITY = ple_pkg::PLE_CAPACITY
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ple_pkg::ple_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ple_pkg::ple_rsp_type rsp_data
);
   import ple_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > 5) ? CW : 5;

   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      count_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   ple_rsp_type        rsp_data_ff;
   ple_rsp_type        rsp_data_in;

   logic               accept;
   logic               is_insert;
   logic               is_remove;
   logic [PW-1:0]      pos_x;
   logic [PW-1:0]      cnt_x;
   logic [PW-1:0]      cnt_next_x;
   logic               full;
   logic               in_range;
   logic               insert_ok;
   logic               remove_ok;
   logic [4:0]         insert_pos;
   ple_cell_ctrl_type  ctrl;

   logic signed [31:0] cell_data [CAPACITY];
   logic [31:0]        cell_read [CAPACITY];
   logic [31:0]        sel_data;

   assign accept    = req_valid && !req_stall;
   assign req_stall = rsp_valid_ff && rsp_stall;

   assign is_insert = (req_data.req_type == OP_INSERT);
   assign is_remove = (req_data.req_type == OP_REMOVE);
   assign pos_x     = PW'(req_data.position);
   assign cnt_x     = PW'(count_ff);
   assign full      = (count_ff == CW'(CAPACITY));
   assign in_range  = (pos_x < cnt_x);
   assign insert_ok = is_insert && !full;
   assign remove_ok = is_remove && in_range;

   // count is below a position of at most 31 here, so it fits
   assign insert_pos = (pos_x > cnt_x) ? cnt_x[4:0] : req_data.position;

   always_comb begin
      ctrl.insert_en = accept && insert_ok;
      ctrl.remove_en = accept && remove_ok;
      ctrl.pos       = is_insert ? insert_pos : req_data.position;
      ctrl.item      = req_data.item_value;
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [31:0] lower;
      logic signed [31:0] upper;
      logic signed [31:0] rd;

      if (g == 0) begin : g_first
         assign lower = 32'sd0;
      end else begin : g_mid_lo
         assign lower = cell_data[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign upper = cell_data[g];
      end else begin : g_mid_hi
         assign upper = cell_data[g+1];
      end

      ple_cell #(
         .IDX(g)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .lower_data(lower),
         .upper_data(upper),
         .data      (cell_data[g]),
         .read_data (rd)
      );

      assign cell_read[g] = rd;
   end

   always_comb begin
      sel_data = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         sel_data = sel_data | cell_read[i];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.insert_en) begin
         count_in = count_ff + CW'(1);
      end else if (ctrl.remove_en) begin
         count_in = count_ff - CW'(1);
      end
   end

   assign cnt_next_x = PW'(count_in);

   always_comb begin
      rsp_data_in.entry_count  = cnt_next_x[4:0];
      rsp_data_in.result_value = 32'sd0;
      rsp_data_in.status       = ST_OK;
      priority if (is_insert) begin
         if (full) begin
            rsp_data_in.status = ST_FULL;
         end
      end else if (!in_range) begin
         rsp_data_in.status = ST_RANGE;
      end else begin
         rsp_data_in.result_value = sel_data;
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("list count above capacity");

   a_accept_gives_rsp : assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted request produced no response");

   a_count_holds : assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(count_ff))
      else $error("count changed without a request");

   a_error_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.status != ST_OK) |-> rsp_data_ff.result_value == 32'sd0)
      else $error("error response carries a value");

   a_full_no_change : assert property (@(posedge clock) disable iff (reset)
      accept && is_insert && full |=> $stable(count_ff))
      else $error("insert into full list changed count");

endmodule
